FILE: rtl/rx_ring_with_history_cursor_assert.svh
// Assertion macros for the receive ring with history cursor.
// Used by modules that have signals named clk and arst_n in scope.
`ifndef RX_RING_WITH_HISTORY_CURSOR_ASSERT_SVH
`define RX_RING_WITH_HISTORY_CURSOR_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every edge outside reset
`define RXH_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define RXH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RXH_ASSERT_ALWAYS(lbl, cond, msg)
`define RXH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/rxh_pkg.sv
// Shared types and constants for the receive ring with history cursor.
// No dependencies.
package rxh_pkg;

	localparam int DEPTH_DEF    = 8192;
	localparam int MAX_READ_DEF = 64;

	localparam int MODE_W = 3;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;

	localparam logic [MODE_W-1:0] MODE_RECEIVE      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READ_UNREAD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DISCARD      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ_HISTORY = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REWIND       = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
		logic              avail;
	} res_t;

endpackage

FILE: rtl/rx_ring_with_history_cursor.sv
// Receive ring buffer with unread tail, history mark and replay cursor.
// Request side: push/full with mode, rx_byte and read_count; a request is
// taken when push is high and full is low. Result side: empty/pop; the
// oldest result sits on out_byte, out_valid, last and unread_available
// while empty is low and leaves on pop.
// Receive, discard and rewind give no result.
// A read gives one result per byte (read_count clamped to MAX_READ), the
// final one flagged by last; a read with nothing to return or a zero count
// gives a single result with out_valid low and last high.
// Bytes stream at one per cycle once a read starts, paced by the single
// read port of the byte store and a four-entry result queue. The back end
// runs one request at a time; a two-entry request queue covers the gap.
// When the receiver stops popping, the result queue fills, the read
// stalls and the request queue backs up to full. Reset clears all
// pointers and queues; the byte store keeps unknown data until written.
// Depends on rxh_pkg, rxh_front, rxh_back, rxh_ram and rxh_outq.
module rx_ring_with_history_cursor #(
	parameter int DEPTH    = rxh_pkg::DEPTH_DEF,
	parameter int MAX_READ = rxh_pkg::MAX_READ_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [rxh_pkg::MODE_W-1:0] mode,
	input  logic [rxh_pkg::BYTE_W-1:0] rx_byte,
	input  logic [rxh_pkg::CNT_W-1:0]  read_count,
	output logic                       empty,
	input  logic                       pop,
	output logic [rxh_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_valid,
	output logic                       last,
	output logic                       unread_available
);

	logic          cmd_vld;
	logic          cmd_pop;
	rxh_pkg::cmd_t cmd;
	logic [2:0]    outq_cnt;
	logic          res_push;
	rxh_pkg::res_t res;
	rxh_pkg::res_t head;

	rxh_front #(
		.MAX_READ (MAX_READ)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.rx_byte    (rx_byte),
		.read_count (read_count),
		.cmd_vld    (cmd_vld),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	rxh_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_vld  (cmd_vld),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.outq_cnt (outq_cnt),
		.res_push (res_push),
		.res      (res)
	);

	rxh_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.cnt      (outq_cnt),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign out_byte         = head.data;
	assign out_valid        = head.valid;
	assign last             = head.last;
	assign unread_available = head.avail;

endmodule

FILE: rtl/rxh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rxh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rxh_front.sv
// Front end: accepts requests, drops unused modes, clamps the read count,
// and holds them in a two-entry command queue. Depends on rxh_pkg.
module rxh_front #(
	parameter int MAX_READ = rxh_pkg::MAX_READ_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [rxh_pkg::MODE_W-1:0]  mode,
	input  logic [rxh_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [rxh_pkg::CNT_W-1:0]   read_count,
	output logic                        cmd_vld,
	output rxh_pkg::cmd_t               cmd,
	input  logic                        cmd_pop
);

	rxh_pkg::cmd_t cmdq_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          keep;
	logic          wr_en;
	rxh_pkg::cmd_t cls;

	always_comb begin
		keep = (mode == rxh_pkg::MODE_RECEIVE) || (mode == rxh_pkg::MODE_READ_UNREAD) ||
			(mode == rxh_pkg::MODE_DISCARD) || (mode == rxh_pkg::MODE_READ_HISTORY) ||
			(mode == rxh_pkg::MODE_REWIND);
		cls.mode = mode;
		cls.data = rx_byte;
		cls.cnt  = (read_count > rxh_pkg::CNT_W'(MAX_READ)) ?
			rxh_pkg::CNT_W'(MAX_READ) : read_count;
	end

	assign full    = (cnt_q == 2'd2);
	assign wr_en   = push && !full && keep;
	assign cmd_vld = (cnt_q != 2'd0);
	assign cmd     = cmdq_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmdq_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, cmd_pop};
		end
	end

endmodule

FILE: rtl/rxh_back.sv
// Back end: owns the byte store and the four ring pointers, carries out
// commands and streams read bytes into the result queue.
// Depends on rxh_pkg, rxh_ram and the assertion header.
`include "rx_ring_with_history_cursor_assert.svh"

module rxh_back #(
	parameter int DEPTH = rxh_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_vld,
	input  rxh_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic [2:0]    outq_cnt,
	output logic          res_push,
	output rxh_pkg::res_t res
);

	localparam int PW = $clog2(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic                      state_q;
	logic [PW-1:0]             wp_q;
	logic [PW-1:0]             unread_q;
	logic [PW-1:0]             hist_q;
	logic [PW-1:0]             replay_q;
	logic                      rd_hist_q;
	logic [rxh_pkg::CNT_W-1:0] cnt_q;

	logic                      vld_s1;
	logic                      use_ram_s1;
	logic                      last_s1;
	logic                      avail_s1;

	logic [PW-1:0]             wp_nxt;
	logic [PW-1:0]             cur_ptr;
	logic [PW-1:0]             cur_nxt;
	logic                      room;
	logic                      step;
	logic                      empty_rd;
	logic                      is_last;
	logic                      step_avail;
	logic                      do_rx;
	logic [rxh_pkg::BYTE_W-1:0] ram_rdata;

	always_comb begin
		wp_nxt   = ring_next(wp_q);
		cur_ptr  = rd_hist_q ? replay_q : unread_q;
		cur_nxt  = ring_next(cur_ptr);
		// count the byte in flight out of the RAM against the queue space
		room     = ({1'b0, outq_cnt} + {3'b000, vld_s1}) < 4'd4;
		step     = (state_q == ST_READ) && room;
		empty_rd = (cnt_q == '0) || (cur_ptr == wp_q);
		is_last  = empty_rd || (cnt_q == rxh_pkg::CNT_W'(1)) || (cur_nxt == wp_q);
		if (empty_rd || rd_hist_q) begin
			step_avail = (unread_q != wp_q);
		end else begin
			step_avail = (cur_nxt != wp_q);
		end
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_vld;
	assign do_rx   = cmd_pop && (cmd.mode == rxh_pkg::MODE_RECEIVE);

	rxh_ram #(
		.WIDTH (rxh_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_rx),
		.waddr (wp_q),
		.wdata (cmd.data),
		.re    (step && !empty_rd),
		.raddr (cur_ptr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			unread_q  <= '0;
			hist_q    <= '0;
			replay_q  <= '0;
			rd_hist_q <= 1'b0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= step;
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.mode)
							rxh_pkg::MODE_RECEIVE: begin
								wp_q <= wp_nxt;
								// drop the oldest byte under any pointer the head lands on
								if (wp_nxt == unread_q) begin
									unread_q <= ring_next(unread_q);
								end
								if (wp_nxt == hist_q) begin
									hist_q <= ring_next(hist_q);
								end
								if (wp_nxt == replay_q) begin
									replay_q <= ring_next(replay_q);
								end
							end
							rxh_pkg::MODE_READ_UNREAD: begin
								state_q   <= ST_READ;
								rd_hist_q <= 1'b0;
								cnt_q     <= cmd.cnt;
							end
							rxh_pkg::MODE_DISCARD: begin
								unread_q <= wp_q;
							end
							rxh_pkg::MODE_READ_HISTORY: begin
								state_q   <= ST_READ;
								rd_hist_q <= 1'b1;
								cnt_q     <= cmd.cnt;
							end
							rxh_pkg::MODE_REWIND: begin
								replay_q <= hist_q;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (step) begin
						if (!empty_rd) begin
							cnt_q <= cnt_q - 1'b1;
							if (rd_hist_q) begin
								replay_q <= cur_nxt;
							end else begin
								unread_q <= cur_nxt;
							end
						end
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			use_ram_s1 <= !empty_rd;
			last_s1    <= is_last;
			avail_s1   <= step_avail;
		end
	end

	assign res_push  = vld_s1;
	assign res.data  = use_ram_s1 ? ram_rdata : '0;
	assign res.valid = use_ram_s1;
	assign res.last  = last_s1;
	assign res.avail = avail_s1;

	`RXH_ASSERT_ALWAYS(a_no_outq_overflow, !(vld_s1 && (outq_cnt == 3'd4)), "result queue overflow")
	`RXH_ASSERT_NEXT(a_last_ends_read, step && is_last, state_q == ST_IDLE, "read did not end on last")
	`RXH_ASSERT_NEXT(a_head_clear_of_readers, do_rx,
		(unread_q != wp_q) && (hist_q != wp_q) && (replay_q != wp_q), "head sits on a read pointer")
	`RXH_ASSERT_NEXT(a_read_step_moves_ptr, step && !empty_rd && !rd_hist_q,
		unread_q == $past(cur_nxt), "unread tail did not advance")

endmodule

FILE: rtl/rxh_outq.sv
// Four-entry result queue between the back end and the result ports.
// Depends on rxh_pkg.
module rxh_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  rxh_pkg::res_t res,
	output logic [2:0]    cnt,
	output logic          empty,
	input  logic          pop,
	output rxh_pkg::res_t head
);

	rxh_pkg::res_t q_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;
	logic          rd_en;

	assign empty = (cnt_q == 3'd0);
	assign cnt   = cnt_q;
	assign rd_en = pop && !empty;
	assign head  = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			q_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (res_push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, res_push} - {2'b00, rd_en};
		end
	end

endmodule

FILE: bench/rx_ring_checker.sv
// Scoreboard for the receive ring with history cursor: follows accepted
// requests, predicts the result stream and compares every popped result.
// Depends on rxh_pkg.
module rx_ring_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [rxh_pkg::MODE_W-1:0] mode,
	input  logic [rxh_pkg::BYTE_W-1:0] rx_byte,
	input  logic [rxh_pkg::CNT_W-1:0]  read_count,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [rxh_pkg::BYTE_W-1:0] out_byte,
	input  logic                       out_valid,
	input  logic                       last,
	input  logic                       unread_available,
	output int                         fail_count,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import rxh_pkg::*;

	localparam int PTR_W = $clog2(DEPTH_DEF);
	typedef logic [PTR_W-1:0] ptr_t;

	logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
	ptr_t head, unread_tail, hist_mark, replay_cur;
	res_t pending_results[$];
	res_t want;

	function automatic ptr_t step_ptr(ptr_t p);
		return (p == ptr_t'(DEPTH_DEF - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// Queue the bytes a read request returns from the unread tail or the replay cursor.
	task automatic predict_read(input logic from_history, input logic [CNT_W-1:0] cnt);
		int limit;
		int n;
		ptr_t cur;
		res_t r;
		limit = (cnt > MAX_READ_DEF) ? MAX_READ_DEF : int'(cnt);
		cur = from_history ? replay_cur : unread_tail;
		n = 0;
		while (n < limit && cur != head) begin
			r.data = ring_mem[cur];
			cur = step_ptr(cur);
			if (from_history)
				replay_cur = cur;
			else
				unread_tail = cur;
			r.valid = 1'b1;
			r.last = 1'b0;
			r.avail = (unread_tail != head);
			pending_results.push_back(r);
			n++;
		end
		if (n == 0) begin
			r.data = '0;
			r.valid = 1'b0;
			r.last = 1'b1;
			r.avail = (unread_tail != head);
			pending_results.push_back(r);
		end else begin
			pending_results[pending_results.size() - 1].last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			unread_tail = '0;
			hist_mark = '0;
			replay_cur = '0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// compare first: a result popped now never belongs to a request taken now
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result byte %02h valid %b last %b avail %b",
							$realtime, out_byte, out_valid, last, unread_available);
				end else begin
					want = pending_results.pop_front();
					if (out_byte !== want.data || out_valid !== want.valid ||
							last !== want.last || unread_available !== want.avail) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: result mismatch: got byte %02h valid %b last %b",
								" avail %b, want byte %02h valid %b last %b avail %b"},
								$realtime, out_byte, out_valid, last, unread_available,
								want.data, want.valid, want.last, want.avail);
					end
				end
			end
			if (push && !full) begin
				case (mode)
				MODE_RECEIVE: begin
					ring_mem[head] = rx_byte;
					head = step_ptr(head);
					// drop the oldest byte under any pointer the head lands on
					if (head == unread_tail)
						unread_tail = step_ptr(unread_tail);
					if (head == hist_mark)
						hist_mark = step_ptr(hist_mark);
					if (head == replay_cur)
						replay_cur = step_ptr(replay_cur);
				end
				MODE_READ_UNREAD: predict_read(1'b0, read_count);
				MODE_DISCARD: unread_tail = head;
				MODE_READ_HISTORY: predict_read(1'b1, read_count);
				MODE_REWIND: replay_cur = hist_mark;
				default: ;
				endcase
			end
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: bench/tb_rx_ring_with_history_cursor.sv
// Testbench top for the receive ring with history cursor: clock, reset,
// request and pop stimulus, and the verdict. Depends on rxh_pkg, the ring
// RTL and rx_ring_checker.
module tb_rx_ring_with_history_cursor;
	timeunit 1ns;
	timeprecision 1ps;

	import rxh_pkg::*;

	localparam int HOLD_CYCLES = 200;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] rx_byte;
	logic [CNT_W-1:0]  read_count;
	logic              empty;
	logic              pop;
	logic [BYTE_W-1:0] out_byte;
	logic              out_valid;
	logic              last;
	logic              unread_available;

	int   fail_count;
	int   outstanding;
	logic req_taken;
	int   burst_left;
	int   hold_asks;
	int   holds_served;

	rx_ring_with_history_cursor dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.rx_byte          (rx_byte),
		.read_count       (read_count),
		.empty            (empty),
		.pop              (pop),
		.out_byte         (out_byte),
		.out_valid        (out_valid),
		.last             (last),
		.unread_available (unread_available)
	);

	rx_ring_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.rx_byte          (rx_byte),
		.read_count       (read_count),
		.empty            (empty),
		.pop              (pop),
		.out_byte         (out_byte),
		.out_valid        (out_valid),
		.last             (last),
		.unread_available (unread_available),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// registered view of the request handshake, read back at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_taken <= 1'b0;
		else
			req_taken <= push && !full;
	end

	// Offer one request in bursts with random gaps; return once it is taken.
	task automatic send_req(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
			input logic [CNT_W-1:0] c);
		if (burst_left == 0) begin
			push = 1'b0;
			repeat ($urandom_range(6, 0)) @(negedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? 60 : $urandom_range(12, 1);
		end
		burst_left--;
		push = 1'b1;
		mode = m;
		rx_byte = b;
		read_count = c;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic send_random_req();
		int pick;
		logic [MODE_W-1:0] m;
		logic [CNT_W-1:0] c;
		pick = $urandom_range(99, 0);
		if (pick < 40)
			m = MODE_RECEIVE;
		else if (pick < 60)
			m = MODE_READ_UNREAD;
		else if (pick < 78)
			m = MODE_READ_HISTORY;
		else if (pick < 84)
			m = MODE_DISCARD;
		else if (pick < 92)
			m = MODE_REWIND;
		else
			m = MODE_W'($urandom_range(7, 5));
		case ($urandom_range(9, 0))
		0: c = '0;
		1: c = CNT_W'($urandom_range(127, 64));
		2: c = CNT_W'($urandom_range(64, 1));
		default: c = CNT_W'($urandom_range(12, 1));
		endcase
		send_req(m, BYTE_W'($urandom), c);
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Receiver: own stall pattern, plus a long hold-off when the sender asks.
	initial begin
		int seg;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (holds_served != hold_asks) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end else begin
				case ($urandom_range(3, 0))
				0: begin
					pop = 1'b1;
					seg = 30;
				end
				3: begin
					pop = 1'b0;
					seg = $urandom_range(6, 1);
				end
				default: begin
					pop = 1'b1;
					seg = $urandom_range(8, 1);
				end
				endcase
				repeat (seg) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		mode = MODE_RECEIVE;
		rx_byte = '0;
		read_count = '0;
		burst_left = 0;
		hold_asks = 0;
		holds_served = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// empty ring: both reads give one invalid result
		send_req(MODE_READ_UNREAD, 8'h5C, 7'd5);
		send_req(MODE_READ_HISTORY, 8'hA3, 7'd1);
		send_req(MODE_RECEIVE, 8'h00, 7'd0);
		send_req(MODE_RECEIVE, 8'hFF, 7'd127);
		send_req(MODE_RECEIVE, 8'hA5, 7'd64);
		send_req(MODE_RECEIVE, 8'h5A, 7'd1);
		// zero count reads nothing and keeps the tail
		send_req(MODE_READ_UNREAD, 8'hFF, 7'd0);
		send_req(MODE_READ_UNREAD, 8'h00, 7'd2);
		// count above the cap saturates
		send_req(MODE_READ_UNREAD, 8'h00, 7'd127);
		send_req(MODE_READ_UNREAD, 8'h00, 7'd1);
		send_req(MODE_READ_HISTORY, 8'h00, 7'd64);
		send_req(MODE_REWIND, 8'hFF, 7'd127);
		send_req(MODE_READ_HISTORY, 8'h00, 7'd100);
		// unused modes must be dropped
		send_req(3'd5, 8'hFF, 7'd127);
		send_req(3'd6, 8'h81, 7'd64);
		send_req(3'd7, 8'h7E, 7'd3);
		send_req(MODE_RECEIVE, 8'h3C, 7'd0);
		send_req(MODE_RECEIVE, 8'hC3, 7'd0);
		send_req(MODE_DISCARD, 8'h00, 7'd0);
		send_req(MODE_READ_UNREAD, 8'h00, 7'd3);
		send_req(MODE_REWIND, 8'h00, 7'd0);
		send_req(MODE_READ_HISTORY, 8'h00, 7'd3);
		send_req(MODE_READ_HISTORY, 8'h00, 7'd65);

		// hold the receiver off while reads pile up and the ring backs up
		repeat (30) send_req(MODE_RECEIVE, BYTE_W'($urandom), CNT_W'($urandom));
		hold_asks++;
		repeat (6) send_req(MODE_READ_UNREAD, 8'h00, 7'd4);
		repeat (6) send_req(MODE_READ_HISTORY, 8'h00, 7'd4);
		wait_drained();

		// drain the unread tail and replay the whole history
		repeat (3) send_req(MODE_READ_UNREAD, 8'h00, 7'd64);
		send_req(MODE_REWIND, 8'h00, 7'd0);
		repeat (2) send_req(MODE_READ_HISTORY, 8'h00, 7'd64);
		wait_drained();

		for (int i = 0; i < 240; i++) begin
			if (i == 120)
				wait_drained();
			send_random_req();
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
